### hdl/chash_pkg.sv
// Shared types, constants and controller/datapath interfaces for the coalesced hash table.
`timescale 1ns / 1ps

package chash_pkg;

    localparam int SLOTS_DEFAULT    = 1024;
    localparam int KEY_BITS_DEFAULT = 31;

    localparam int KEY_W    = KEY_BITS_DEFAULT;
    localparam int SLOT_W   = $clog2(SLOTS_DEFAULT);
    localparam int SIZE_W   = SLOT_W + 1;
    localparam int PROBES_W = $clog2(SLOTS_DEFAULT + 1);

    localparam logic [SIZE_W-1:0] TSIZE_RESET = SIZE_W'(SLOTS_DEFAULT);

    typedef enum logic
    {
        OP_INSERT = 1'b0,
        OP_LOOKUP = 1'b1
    } op_t;

    typedef enum logic [1:0]
    {
        ST_INSERTED  = 2'd0,
        ST_FULL      = 2'd1,
        ST_FOUND     = 2'd2,
        ST_NOT_FOUND = 2'd3
    } status_t;

    typedef struct packed
    {
        op_t               opcode;
        logic [KEY_W-1:0]  key;
    } item_t;

    typedef struct packed
    {
        status_t             status;
        logic [PROBES_W-1:0] probes;
        logic [SLOT_W-1:0]   slot;
    } result_t;

    typedef enum logic [1:0]
    {
        ADDR_CLR,
        ADDR_IDX,
        ADDR_SCAN,
        ADDR_FREE
    } addr_sel_t;

    typedef enum logic [1:0]
    {
        SLOT_NONE,
        SLOT_IDX,
        SLOT_FREE
    } slot_sel_t;

    typedef struct packed
    {
        logic      accept;
        logic      load_home;
        logic      cnt_clr;
        logic      follow;
        addr_sel_t addr_sel;
        logic      clr_step;
        logic      wr_new;
        logic      new_null;
        logic      wr_link;
        logic      scan_start;
        logic      scan_step;
        logic      take_free;
        logic      emit;
        status_t   emit_status;
        slot_sel_t slot_sel;
    } dp_cmd_t;

    typedef struct packed
    {
        logic clr_last;
        logic rem_done;
        logic is_lookup;
        logic used;
        logic match;
        logic link_ok;
        logic chk_free;
        logic chk_last;
    } dp_stat_t;

endpackage

### hdl/chash_rem.sv
// Bit-serial remainder unit: key modulo active table size, one key bit per cycle.
`timescale 1ns / 1ps

module chash_rem #(
    parameter int KEY_BITS = chash_pkg::KEY_BITS_DEFAULT,
    parameter int DIV_W    = 11
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [KEY_BITS-1:0] dividend,
    input  logic [DIV_W-1:0]    divisor,
    output logic                done,
    output logic [DIV_W-1:0]    rem
);

    localparam int CW = $clog2(KEY_BITS + 1);

    logic [CW-1:0]       cnt_reg;
    logic [KEY_BITS-1:0] sh_reg;
    logic [DIV_W-1:0]    div_reg;
    logic [DIV_W-1:0]    rem_reg;
    logic [DIV_W:0]      trial;
    logic [DIV_W:0]      diff;
    logic [DIV_W-1:0]    rem_next;

    always_comb
    begin
        trial = {rem_reg, sh_reg[KEY_BITS-1]};
        diff  = trial - {1'b0, div_reg};
        if (trial >= {1'b0, div_reg})
        begin
            rem_next = diff[DIV_W-1:0];
        end
        else
        begin
            rem_next = trial[DIV_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (start)
        begin
            cnt_reg <= CW'(KEY_BITS);
        end
        else if (cnt_reg != '0)
        begin
            cnt_reg <= cnt_reg - CW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            sh_reg  <= dividend;
            div_reg <= divisor;
            rem_reg <= '0;
        end
        else if (cnt_reg != '0)
        begin
            sh_reg  <= {sh_reg[KEY_BITS-2:0], 1'b0};
            rem_reg <= rem_next;
        end
    end

    assign done = (cnt_reg == '0);
    assign rem  = rem_reg;

endmodule

### hdl/chash_dp.sv
// Datapath: slot memories, chain and scan registers, size register and result register.
`timescale 1ns / 1ps

module chash_dp #(
    parameter int SLOTS    = chash_pkg::SLOTS_DEFAULT,
    parameter int KEY_BITS = chash_pkg::KEY_BITS_DEFAULT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  chash_pkg::item_t                item,
    input  logic                            cfg_we,
    input  logic [chash_pkg::SIZE_W-1:0]    cfg_wdata,
    input  chash_pkg::dp_cmd_t              cmd,
    output chash_pkg::dp_stat_t             stat,
    output logic                            done,
    output chash_pkg::result_t              result
);

    localparam int IDX_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int LINK_W = IDX_W + 1;
    localparam int CNT_W  = $clog2(SLOTS + 1);

    localparam logic [LINK_W-1:0] LINK_NULL = '1;
    localparam logic [LINK_W-1:0] SLOTS_L   = LINK_W'(SLOTS);
    localparam logic [CNT_W-1:0]  SLOTS_C   = CNT_W'(SLOTS);
    localparam logic [IDX_W-1:0]  LAST_IDX  = IDX_W'(SLOTS - 1);

    // slot storage
    logic [KEY_BITS-1:0] key_mem  [SLOTS];
    logic                used_mem [SLOTS];
    logic [LINK_W-1:0]   next_mem [SLOTS];

    logic [KEY_BITS-1:0] rd_key_reg;
    logic                rd_used_reg;
    logic [LINK_W-1:0]   rd_next_reg;

    logic [chash_pkg::SIZE_W-1:0] tsize_reg;
    chash_pkg::op_t      op_reg;
    logic [KEY_BITS-1:0] key_reg;
    logic [CNT_W-1:0]    n_reg;
    logic [IDX_W-1:0]    idx_reg;
    logic [CNT_W-1:0]    cnt_reg;
    logic [IDX_W-1:0]    free_reg;
    logic [IDX_W-1:0]    scan_reg;
    logic                scan_live_reg;
    logic                chk_valid_reg;
    logic [IDX_W-1:0]    chk_addr_reg;
    logic [IDX_W-1:0]    clr_reg;
    logic                done_reg;
    chash_pkg::result_t  result_reg;
    chash_pkg::result_t  result_next;

    logic [31:0]         ts32;
    logic [31:0]         n32;
    logic [CNT_W-1:0]    n_comb;
    logic [CNT_W-1:0]    n_m1;
    logic [KEY_BITS-1:0] key_in;
    logic [CNT_W-1:0]    rem;
    logic                rem_done;
    logic [IDX_W-1:0]    addr;
    logic                key_we;
    logic                used_we;
    logic                next_we;
    logic [LINK_W-1:0]   next_wd;

    // active size: zero acts as one, capped at the slot count
    always_comb
    begin
        ts32 = 32'(tsize_reg);
        if (ts32 == 32'd0)
        begin
            n32 = 32'd1;
        end
        else if (ts32 > 32'(SLOTS))
        begin
            n32 = 32'(SLOTS);
        end
        else
        begin
            n32 = ts32;
        end
        n_comb = n32[CNT_W-1:0];
        n_m1   = n_reg - CNT_W'(1);
        key_in = KEY_BITS'(item.key);
    end

    chash_rem #(
        .KEY_BITS (KEY_BITS),
        .DIV_W    (CNT_W)
    ) u_rem (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.accept),
        .dividend (key_in),
        .divisor  (n_comb),
        .done     (rem_done),
        .rem      (rem)
    );

    always_comb
    begin
        case (cmd.addr_sel)
            chash_pkg::ADDR_CLR:  addr = clr_reg;
            chash_pkg::ADDR_IDX:  addr = idx_reg;
            chash_pkg::ADDR_SCAN: addr = scan_reg;
            chash_pkg::ADDR_FREE: addr = free_reg;
            default:              addr = idx_reg;
        endcase
        key_we  = cmd.wr_new;
        used_we = cmd.wr_new || cmd.clr_step;
        next_we = cmd.clr_step || (cmd.wr_new && cmd.new_null) || cmd.wr_link;
        next_wd = cmd.wr_link ? {1'b0, free_reg} : LINK_NULL;
    end

    always_ff @(posedge clk)
    begin
        if (key_we)
        begin
            key_mem[addr] <= key_reg;
        end
        rd_key_reg <= key_mem[addr];
    end

    always_ff @(posedge clk)
    begin
        if (used_we)
        begin
            used_mem[addr] <= cmd.wr_new;
        end
        rd_used_reg <= used_mem[addr];
    end

    always_ff @(posedge clk)
    begin
        if (next_we)
        begin
            next_mem[addr] <= next_wd;
        end
        rd_next_reg <= next_mem[addr];
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tsize_reg     <= chash_pkg::TSIZE_RESET;
            clr_reg       <= '0;
            scan_live_reg <= 1'b0;
            chk_valid_reg <= 1'b0;
            done_reg      <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                tsize_reg <= cfg_wdata;
            end
            if (cmd.clr_step)
            begin
                clr_reg <= clr_reg + IDX_W'(1);
            end
            if (cmd.scan_start)
            begin
                scan_live_reg <= 1'b1;
            end
            else if (cmd.scan_step && scan_live_reg && scan_reg == '0)
            begin
                scan_live_reg <= 1'b0;
            end
            chk_valid_reg <= cmd.scan_step && scan_live_reg;
            done_reg      <= cmd.emit;
        end
    end

    always_comb
    begin
        result_next.status = cmd.emit_status;
        result_next.probes = (op_reg == chash_pkg::OP_LOOKUP)
                           ? chash_pkg::PROBES_W'(cnt_reg) : '0;
        case (cmd.slot_sel)
            chash_pkg::SLOT_IDX:  result_next.slot = chash_pkg::SLOT_W'(idx_reg);
            chash_pkg::SLOT_FREE: result_next.slot = chash_pkg::SLOT_W'(free_reg);
            default:              result_next.slot = '0;
        endcase
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            op_reg  <= item.opcode;
            key_reg <= key_in;
            n_reg   <= n_comb;
        end
        if (cmd.load_home)
        begin
            idx_reg <= rem[IDX_W-1:0];
            cnt_reg <= CNT_W'(1);
        end
        else if (cmd.follow)
        begin
            idx_reg <= rd_next_reg[IDX_W-1:0];
            cnt_reg <= cnt_reg + CNT_W'(1);
        end
        else if (cmd.cnt_clr)
        begin
            cnt_reg <= '0;
        end
        if (cmd.scan_start)
        begin
            scan_reg <= n_m1[IDX_W-1:0];
        end
        else if (cmd.scan_step && scan_live_reg && scan_reg != '0)
        begin
            scan_reg <= scan_reg - IDX_W'(1);
        end
        if (cmd.scan_step)
        begin
            chk_addr_reg <= scan_reg;
        end
        if (cmd.take_free)
        begin
            free_reg <= chk_addr_reg;
        end
        if (cmd.emit)
        begin
            result_reg <= result_next;
        end
    end

    always_comb
    begin
        stat.clr_last  = (clr_reg == LAST_IDX);
        stat.rem_done  = rem_done;
        stat.is_lookup = (op_reg == chash_pkg::OP_LOOKUP);
        stat.used      = rd_used_reg;
        stat.match     = rd_used_reg && (rd_key_reg == key_reg);
        stat.link_ok   = (rd_next_reg < SLOTS_L) && (cnt_reg < SLOTS_C);
        stat.chk_free  = chk_valid_reg && !rd_used_reg;
        stat.chk_last  = chk_valid_reg && rd_used_reg && (chk_addr_reg == '0);
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

### hdl/chash_ctrl.sv
// Controller: sequences clearing, home hashing, free-slot scan, chain walks and result beats.
`timescale 1ns / 1ps

module chash_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  chash_pkg::dp_stat_t  stat,
    output chash_pkg::dp_cmd_t   cmd
);

    typedef enum logic [3:0]
    {
        S_CLEAR,
        S_IDLE,
        S_DIV,
        S_HOME_RD,
        S_HOME_CHK,
        S_SCAN,
        S_FILL,
        S_WALK_RD,
        S_WALK_CHK
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   busy_reg;
    logic   busy_next;

    always_comb
    begin
        state_next      = state_reg;
        busy_next       = busy_reg;
        cmd             = '0;
        cmd.addr_sel    = chash_pkg::ADDR_IDX;
        cmd.emit_status = chash_pkg::ST_INSERTED;
        cmd.slot_sel    = chash_pkg::SLOT_NONE;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.addr_sel = chash_pkg::ADDR_CLR;
                cmd.clr_step = 1'b1;
                if (stat.clr_last)
                begin
                    state_next = S_IDLE;
                    busy_next  = 1'b0;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.accept = 1'b1;
                    state_next = S_DIV;
                    busy_next  = 1'b1;
                end
            end
            S_DIV:
            begin
                if (stat.rem_done)
                begin
                    cmd.load_home = 1'b1;
                    state_next    = S_HOME_RD;
                end
            end
            S_HOME_RD:
            begin
                state_next = S_HOME_CHK;
            end
            S_HOME_CHK:
            begin
                if (stat.is_lookup)
                begin
                    if (stat.match)
                    begin
                        cmd.emit        = 1'b1;
                        cmd.emit_status = chash_pkg::ST_FOUND;
                        cmd.slot_sel    = chash_pkg::SLOT_IDX;
                        state_next      = S_IDLE;
                        busy_next       = 1'b0;
                    end
                    else if (!stat.link_ok)
                    begin
                        cmd.emit        = 1'b1;
                        cmd.emit_status = chash_pkg::ST_NOT_FOUND;
                        state_next      = S_IDLE;
                        busy_next       = 1'b0;
                    end
                    else
                    begin
                        cmd.follow = 1'b1;
                        state_next = S_HOME_RD;
                    end
                end
                else if (!stat.used)
                begin
                    cmd.wr_new      = 1'b1;
                    cmd.emit        = 1'b1;
                    cmd.emit_status = chash_pkg::ST_INSERTED;
                    cmd.slot_sel    = chash_pkg::SLOT_IDX;
                    state_next      = S_IDLE;
                    busy_next       = 1'b0;
                end
                else
                begin
                    cmd.scan_start = 1'b1;
                    state_next     = S_SCAN;
                end
            end
            S_SCAN:
            begin
                cmd.addr_sel  = chash_pkg::ADDR_SCAN;
                cmd.scan_step = 1'b1;
                if (stat.chk_free)
                begin
                    cmd.take_free = 1'b1;
                    state_next    = S_FILL;
                end
                else if (stat.chk_last)
                begin
                    cmd.emit        = 1'b1;
                    cmd.emit_status = chash_pkg::ST_FULL;
                    state_next      = S_IDLE;
                    busy_next       = 1'b0;
                end
            end
            S_FILL:
            begin
                cmd.addr_sel = chash_pkg::ADDR_FREE;
                cmd.wr_new   = 1'b1;
                cmd.new_null = 1'b1;
                cmd.cnt_clr  = 1'b1;
                state_next   = S_WALK_RD;
            end
            S_WALK_RD:
            begin
                state_next = S_WALK_CHK;
            end
            S_WALK_CHK:
            begin
                if (stat.link_ok)
                begin
                    cmd.follow = 1'b1;
                    state_next = S_WALK_RD;
                end
                else
                begin
                    cmd.wr_link     = 1'b1;
                    cmd.emit        = 1'b1;
                    cmd.emit_status = chash_pkg::ST_INSERTED;
                    cmd.slot_sel    = chash_pkg::SLOT_FREE;
                    state_next      = S_IDLE;
                    busy_next       = 1'b0;
                end
            end
            default:
            begin
                state_next = S_IDLE;
                busy_next  = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            busy_reg  <= 1'b1;
        end
        else
        begin
            state_reg <= state_next;
            busy_reg  <= busy_next;
        end
    end

    assign busy = busy_reg;

endmodule

### hdl/coalesced_hash_table.sv
// Coalesced hash table (late-insertion standard) top level: controller plus datapath.
`timescale 1ns / 1ps
//
// Command channel: drive item with start; the beat is taken at a rising edge where
// start is high and busy is low. One result beat follows each command: result is valid
// for exactly one cycle while done is high, and cannot be held off by the receiver.
// Configuration: cfg_we with cfg_wdata writes the size register; write only while busy
// is low.
// The home slot is found by a bit-serial remainder unit, one key bit a cycle. A lookup
// then walks the chain from the home slot until a match or the chain end. An insert
// takes an empty home slot, or else scans the active size for a free slot, fills it and
// links it at the end of the chain; if the scan finds no free slot the table is full.
// Each chain step is a registered memory read, then a check; the free-slot scan checks
// one slot a cycle. busy drops in the cycle the result beat is shown, so the
// next command may be taken then. One command is in flight at a time.
// After reset a clearing pass empties all SLOTS slots with busy high;
// configuration writes are taken during it. The size register resets to 1024.
//
module coalesced_hash_table #(
    parameter int SLOTS    = chash_pkg::SLOTS_DEFAULT,
    parameter int KEY_BITS = chash_pkg::KEY_BITS_DEFAULT
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  chash_pkg::item_t             item,
    output logic                         done,
    output chash_pkg::result_t           result,
    input  logic                         cfg_we,
    input  logic [chash_pkg::SIZE_W-1:0] cfg_wdata
);

    chash_pkg::dp_cmd_t  cmd;
    chash_pkg::dp_stat_t stat;

    chash_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .stat  (stat),
        .cmd   (cmd)
    );

    chash_dp #(
        .SLOTS    (SLOTS),
        .KEY_BITS (KEY_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd),
        .stat      (stat),
        .done      (done),
        .result    (result)
    );

endmodule
